/* sv/scp_pkg.sv */
// Shared types, character codes and digit decode for the command line parser.
package scp_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int OUT_WIDTH           = 16;
   localparam int DEC_BASE            = 10;
   localparam int HEX_SHIFT           = 4;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_W     = 8'h77;
   localparam logic [7:0] CHAR_X     = 8'h78;

   typedef enum logic [3:0] {
      PH_START,
      PH_LETTER,
      PH_SP1,
      PH_N1_ZERO,
      PH_N1_ZEROX,
      PH_N1_DIGS,
      PH_SP2,
      PH_DASH,
      PH_N2_ZERO,
      PH_N2_ZEROX,
      PH_N2_DIGS,
      PH_DONE,
      PH_DEAD
   } phase_type;

   typedef enum logic [2:0] {
      KIND_READ_BYTE  = 3'd0,
      KIND_READ_COUNT = 3'd1,
      KIND_READ_RANGE = 3'd2,
      KIND_WRITE_BYTE = 3'd3,
      KIND_UNKNOWN    = 3'd4
   } kind_type;

   typedef struct packed {
      phase_type phase;
      logic      is_write;
      logic      hex_mode;
      kind_type  kind;
   } ctrl_type;

   typedef struct packed {
      kind_type                kind;
      logic [OUT_WIDTH-1:0]    first_value;
      logic [OUT_WIDTH-1:0]    second_value;
   } result_type;

   localparam ctrl_type CTRL_RESET = '{
      phase:    PH_START,
      is_write: 1'b0,
      hex_mode: 1'b0,
      kind:     KIND_UNKNOWN
   };

   // Bit 4 flags a digit, bits 3:0 carry its value.
   function automatic logic [4:0] digit_decode(input logic [7:0] c, input logic hex);
      logic [4:0] dig;
      dig = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         dig = {1'b1, c[3:0]};
      end else if (hex && (c inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
         dig = {1'b1, c[3:0] + 4'd9};
      end
      return dig;
   endfunction

endpackage

/* sv/scp_if.sv */
// Valid/ready channel interfaces for command characters and parse results.
interface scp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface scp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command_kind;
   logic [15:0] first_value;
   logic [15:0] second_value;

   modport source (output valid, output command_kind, output first_value,
                   output second_value, input ready);
   modport sink   (input valid, input command_kind, input first_value,
                   input second_value, output ready);
endinterface

/* sv/scp_step.sv */
// Per-character grammar step: next parser state and the result on NUL.
module scp_step #(
   parameter int VALUE_WIDTH = scp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic [7:0]             char_code,
   input  scp_pkg::ctrl_type      ctrl_cur,
   input  logic [VALUE_WIDTH-1:0] acc_cur,
   input  logic [VALUE_WIDTH-1:0] hold_cur,
   output scp_pkg::ctrl_type      ctrl_nxt,
   output logic [VALUE_WIDTH-1:0] acc_nxt,
   output logic [VALUE_WIDTH-1:0] hold_nxt,
   output logic                   res_valid,
   output scp_pkg::result_type    res
);

   logic [4:0]             dig_dec;
   logic [4:0]             dig_any;
   logic [VALUE_WIDTH-1:0] scaled;
   logic [VALUE_WIDTH-1:0] acc_added;
   logic                   is_zero;
   logic                   is_nonzero;
   logic                   begun;
   logic [VALUE_WIDTH-1:0] acc_start;
   scp_pkg::phase_type     end_first_phase;

   always_comb begin
      dig_dec    = scp_pkg::digit_decode(char_code, 1'b0);
      dig_any    = scp_pkg::digit_decode(char_code, ctrl_cur.hex_mode);
      scaled     = ctrl_cur.hex_mode ? (acc_cur << scp_pkg::HEX_SHIFT)
                                     : acc_cur * VALUE_WIDTH'(scp_pkg::DEC_BASE);
      acc_added  = scaled + VALUE_WIDTH'(dig_any[3:0]);
      is_zero    = (char_code == scp_pkg::CHAR_ZERO);
      is_nonzero = (char_code inside {[8'h31:8'h39]});
      begun      = is_zero || is_nonzero;
      acc_start  = is_nonzero ? VALUE_WIDTH'(char_code[3:0]) : '0;
      if (char_code == scp_pkg::CHAR_SPACE) begin
         end_first_phase = scp_pkg::PH_SP2;
      end else if (char_code == scp_pkg::CHAR_DASH && !ctrl_cur.is_write) begin
         end_first_phase = scp_pkg::PH_DASH;
      end else begin
         end_first_phase = scp_pkg::PH_DEAD;
      end
   end

   always_comb begin
      ctrl_nxt             = ctrl_cur;
      acc_nxt              = acc_cur;
      hold_nxt             = hold_cur;
      res_valid            = 1'b0;
      res.kind             = scp_pkg::KIND_UNKNOWN;
      res.first_value      = '0;
      res.second_value     = '0;

      if (char_code == scp_pkg::CHAR_NUL) begin
         // End of line: emit the beat and return to the start of a command.
         res_valid = 1'b1;
         case (ctrl_cur.phase)
            scp_pkg::PH_N1_ZERO, scp_pkg::PH_N1_DIGS: begin
               if (!ctrl_cur.is_write) begin
                  res.kind        = scp_pkg::KIND_READ_BYTE;
                  res.first_value = scp_pkg::OUT_WIDTH'(acc_cur);
               end
            end
            scp_pkg::PH_N2_ZERO, scp_pkg::PH_N2_ZEROX, scp_pkg::PH_N2_DIGS,
            scp_pkg::PH_DONE: begin
               res.kind         = ctrl_cur.kind;
               res.first_value  = scp_pkg::OUT_WIDTH'(hold_cur);
               res.second_value = scp_pkg::OUT_WIDTH'(acc_cur);
            end
            default: begin
            end
         endcase
         ctrl_nxt = scp_pkg::CTRL_RESET;
         acc_nxt  = '0;
         hold_nxt = '0;
      end else begin
         case (ctrl_cur.phase)
            scp_pkg::PH_START: begin
               if (char_code == scp_pkg::CHAR_R || char_code == scp_pkg::CHAR_W) begin
                  ctrl_nxt.is_write = (char_code == scp_pkg::CHAR_W);
                  ctrl_nxt.phase    = scp_pkg::PH_LETTER;
               end else begin
                  ctrl_nxt.phase = scp_pkg::PH_DEAD;
               end
            end
            scp_pkg::PH_LETTER: begin
               ctrl_nxt.phase = (char_code == scp_pkg::CHAR_SPACE) ? scp_pkg::PH_SP1
                                                                    : scp_pkg::PH_DEAD;
            end
            scp_pkg::PH_SP1: begin
               if (begun) begin
                  ctrl_nxt.phase    = is_zero ? scp_pkg::PH_N1_ZERO : scp_pkg::PH_N1_DIGS;
                  ctrl_nxt.hex_mode = 1'b0;
                  acc_nxt           = acc_start;
               end else if (char_code != scp_pkg::CHAR_SPACE) begin
                  ctrl_nxt.phase = scp_pkg::PH_DEAD;
               end
            end
            scp_pkg::PH_N1_ZERO: begin
               if (char_code == scp_pkg::CHAR_X) begin
                  ctrl_nxt.phase = scp_pkg::PH_N1_ZEROX;
               end else if (dig_dec[4]) begin
                  acc_nxt        = VALUE_WIDTH'(dig_dec[3:0]);
                  ctrl_nxt.phase = scp_pkg::PH_N1_DIGS;
               end else begin
                  hold_nxt       = acc_cur;
                  ctrl_nxt.phase = end_first_phase;
               end
            end
            scp_pkg::PH_N1_ZEROX: begin
               if (dig_any[4] || scp_pkg::digit_decode(char_code, 1'b1) != 5'd0) begin
                  ctrl_nxt.hex_mode = 1'b1;
                  acc_nxt           = VALUE_WIDTH'(scp_pkg::digit_decode(char_code, 1'b1)
                                                   & 5'h0f);
                  ctrl_nxt.phase    = scp_pkg::PH_N1_DIGS;
               end else begin
                  ctrl_nxt.phase = scp_pkg::PH_DEAD;
               end
            end
            scp_pkg::PH_N1_DIGS: begin
               if (dig_any[4]) begin
                  acc_nxt = acc_added;
               end else begin
                  hold_nxt       = acc_cur;
                  ctrl_nxt.phase = end_first_phase;
               end
            end
            scp_pkg::PH_SP2: begin
               if (begun) begin
                  ctrl_nxt.phase    = is_zero ? scp_pkg::PH_N2_ZERO : scp_pkg::PH_N2_DIGS;
                  ctrl_nxt.hex_mode = 1'b0;
                  ctrl_nxt.kind     = ctrl_cur.is_write ? scp_pkg::KIND_WRITE_BYTE
                                                        : scp_pkg::KIND_READ_COUNT;
                  acc_nxt           = acc_start;
               end else if (char_code != scp_pkg::CHAR_SPACE) begin
                  ctrl_nxt.phase = scp_pkg::PH_DEAD;
               end
            end
            scp_pkg::PH_DASH: begin
               if (begun) begin
                  ctrl_nxt.phase    = is_zero ? scp_pkg::PH_N2_ZERO : scp_pkg::PH_N2_DIGS;
                  ctrl_nxt.hex_mode = 1'b0;
                  ctrl_nxt.kind     = scp_pkg::KIND_READ_RANGE;
                  acc_nxt           = acc_start;
               end else begin
                  ctrl_nxt.phase = scp_pkg::PH_DEAD;
               end
            end
            scp_pkg::PH_N2_ZERO: begin
               if (char_code == scp_pkg::CHAR_X) begin
                  ctrl_nxt.phase = scp_pkg::PH_N2_ZEROX;
               end else if (dig_dec[4]) begin
                  acc_nxt        = VALUE_WIDTH'(dig_dec[3:0]);
                  ctrl_nxt.phase = scp_pkg::PH_N2_DIGS;
               end else begin
                  ctrl_nxt.phase = scp_pkg::PH_DONE;
               end
            end
            scp_pkg::PH_N2_ZEROX: begin
               if (scp_pkg::digit_decode(char_code, 1'b1) != 5'd0) begin
                  ctrl_nxt.hex_mode = 1'b1;
                  acc_nxt           = VALUE_WIDTH'(scp_pkg::digit_decode(char_code, 1'b1)
                                                   & 5'h0f);
                  ctrl_nxt.phase    = scp_pkg::PH_N2_DIGS;
               end else begin
                  ctrl_nxt.phase = scp_pkg::PH_DONE;
               end
            end
            scp_pkg::PH_N2_DIGS: begin
               if (dig_any[4]) begin
                  acc_nxt = acc_added;
               end else begin
                  ctrl_nxt.phase = scp_pkg::PH_DONE;
               end
            end
            scp_pkg::PH_DONE: begin
            end
            default: begin
               ctrl_nxt.phase = scp_pkg::PH_DEAD;
            end
         endcase
      end
   end

endmodule

/* sv/serial_command_line_parser.sv */
// Streaming command line parser: character register, grammar step, two-entry result queue.
//
// One character is taken per clock cycle, back to back. Each accepted character is held in
// the input register, where the grammar step updates the parser state; a NUL character
// completes the command and its result beat is pushed into a two-entry output queue, so
// rsp_chan.valid rises once that beat is registered in the queue. The queue lets the input
// keep flowing while one result waits; the input stalls only when both entries are full
// and the consumer takes neither. Numbers accumulate over VALUE_WIDTH bits and leave as
// their low 16 bits, zero extended when VALUE_WIDTH is below 16.
module serial_command_line_parser #(
   parameter int VALUE_WIDTH = scp_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   scp_req_if.sink   req_chan,
   scp_rsp_if.source rsp_chan
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [7:0]             in_char_ff;
   scp_pkg::ctrl_type      ctrl_ff;
   scp_pkg::ctrl_type      ctrl_in;
   logic [VALUE_WIDTH-1:0] acc_ff;
   logic [VALUE_WIDTH-1:0] acc_in;
   logic [VALUE_WIDTH-1:0] hold_ff;
   logic [VALUE_WIDTH-1:0] hold_in;

   logic                   step_res_valid;
   scp_pkg::result_type    step_res;

   scp_pkg::result_type    queue_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;

   logic                   req_fire;
   logic                   step_fire;
   logic                   push;
   logic                   pop;

   scp_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_step (
      .char_code (in_char_ff),
      .ctrl_cur  (ctrl_ff),
      .acc_cur   (acc_ff),
      .hold_cur  (hold_ff),
      .ctrl_nxt  (ctrl_in),
      .acc_nxt   (acc_in),
      .hold_nxt  (hold_in),
      .res_valid (step_res_valid),
      .res       (step_res)
   );

   // Advance the held character only when the queue can take a beat.
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign step_fire = in_valid_ff && (count_ff != 2'd2 || pop);
   assign push      = step_fire && step_res_valid;
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign req_fire  = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ctrl_ff     <= scp_pkg::CTRL_RESET;
         acc_ff      <= '0;
         hold_ff     <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         if (step_fire) begin
            ctrl_ff <= ctrl_in;
            acc_ff  <= acc_in;
            hold_ff <= hold_in;
         end
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_chan.char_code;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= step_res;
      end
   end

   assign rsp_chan.valid        = (count_ff != 2'd0);
   assign rsp_chan.command_kind = queue_ff[rd_ptr_ff].kind;
   assign rsp_chan.first_value  = queue_ff[rd_ptr_ff].first_value;
   assign rsp_chan.second_value = queue_ff[rd_ptr_ff].second_value;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("result beat pushed into a full queue");

   a_push_on_nul: assert property (@(posedge clock) disable iff (reset)
      push |-> (in_char_ff == scp_pkg::CHAR_NUL))
      else $error("result beat from a non-terminating character");

   a_restart_after_nul: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_char_ff == scp_pkg::CHAR_NUL) |=>
         (ctrl_ff.phase == scp_pkg::PH_START && acc_ff == '0))
      else $error("parser did not return to start after end of line");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!in_valid_ff && count_ff == 2'd0 &&
                        ctrl_ff.phase == scp_pkg::PH_START))
      else $error("control state not cleared by reset");

endmodule
